>>> rtl/core/assert_macros.svh
// Assertion macros for the core, clocked on clk; TFN_ASSERT is held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define TFN_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TFN_ASSERT(lbl, prop)
`define TFN_ASSERT_RST(lbl, prop)
`endif
`endif

>>> rtl/core/tfn_pkg.sv
`default_nettype none
package tfn_pkg;

  // Port and output formats.
  localparam int FIELD_W         = 32;
  localparam int OUT_W           = 16;
  localparam int COORD_WIDTH_DEF = 32;

  // Normalization: the largest magnitude is scaled into [2^29, 2^30).
  localparam int NORM_BITS  = 30;
  localparam int SQ_W       = 2 * NORM_BITS;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int UNIT_SHIFT = 14;
  localparam int QUO_W      = UNIT_SHIFT + 1;
  localparam int NUM_W      = NORM_BITS + QUO_W + 1;
  localparam int DVS_W      = ROOT_W + 1;

  // Word handed from one square root cell to the next.
  typedef struct packed {
    logic                           vld;
    logic [SUM_W-1:0]               rem;
    logic [ROOT_W-1:0]              root;
    logic [2:0][NORM_BITS-1:0]      u;
    logic [2:0]                     neg;
    logic                           degen;
  } sqrt_word_t;

  // Word handed from one divider cell to the next, three lanes sharing a divisor.
  typedef struct packed {
    logic                           vld;
    logic [2:0][NUM_W-1:0]          rem;
    logic [DVS_W-1:0]               dvs;
    logic [2:0][QUO_W-1:0]          quo;
    logic [2:0]                     neg;
    logic                           degen;
  } div_word_t;

endpackage
`default_nettype wire

>>> rtl/core/triangle_face_normal_top.sv
// Throughput: one triangle per cycle; the whole pipeline advances together and
// holds while the output word waits for out_ready.
// The pipeline runs through the 31-cell square root chain and the 15-cell divider chain.
// Reset (rst, synchronous) clears every stage valid bit; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module triangle_face_normal_top #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [tfn_pkg::FIELD_W-1:0] first_x,
  input  wire  [tfn_pkg::FIELD_W-1:0] first_y,
  input  wire  [tfn_pkg::FIELD_W-1:0] first_z,
  input  wire  [tfn_pkg::FIELD_W-1:0] middle_x,
  input  wire  [tfn_pkg::FIELD_W-1:0] middle_y,
  input  wire  [tfn_pkg::FIELD_W-1:0] middle_z,
  input  wire  [tfn_pkg::FIELD_W-1:0] third_x,
  input  wire  [tfn_pkg::FIELD_W-1:0] third_y,
  input  wire  [tfn_pkg::FIELD_W-1:0] third_z,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [tfn_pkg::OUT_W-1:0]   normal_x,
  output logic [tfn_pkg::OUT_W-1:0]   normal_y,
  output logic [tfn_pkg::OUT_W-1:0]   normal_z,
  output logic                        degenerate
);

  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int BLW = $clog2(PW + 1);
  localparam int NB  = tfn_pkg::NORM_BITS;
  localparam int SQC = tfn_pkg::ROOT_W;
  localparam int DVC = tfn_pkg::QUO_W;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Sign-extended coordinates.
  logic signed [EW-1:0] fx, fy, fz, mx, my, mz, tx, ty, tz;
  assign fx = {first_x[COORD_WIDTH-1],  first_x[COORD_WIDTH-1:0]};
  assign fy = {first_y[COORD_WIDTH-1],  first_y[COORD_WIDTH-1:0]};
  assign fz = {first_z[COORD_WIDTH-1],  first_z[COORD_WIDTH-1:0]};
  assign mx = {middle_x[COORD_WIDTH-1], middle_x[COORD_WIDTH-1:0]};
  assign my = {middle_y[COORD_WIDTH-1], middle_y[COORD_WIDTH-1:0]};
  assign mz = {middle_z[COORD_WIDTH-1], middle_z[COORD_WIDTH-1:0]};
  assign tx = {third_x[COORD_WIDTH-1],  third_x[COORD_WIDTH-1:0]};
  assign ty = {third_y[COORD_WIDTH-1],  third_y[COORD_WIDTH-1:0]};
  assign tz = {third_z[COORD_WIDTH-1],  third_z[COORD_WIDTH-1:0]};

  // Stage valid bits for the front end.
  logic [6:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // Edges a = third - middle and b = first - middle.
  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= tx - mx;
      ay <= ty - my;
      az <= tz - mz;
      bx <= fx - mx;
      by <= fy - my;
      bz <= fz - mz;
    end
  end

  // Six cross product terms.
  logic signed [PW-1:0] prod [6];
  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0] <= ay * bz;
      prod[1] <= az * by;
      prod[2] <= az * bx;
      prod[3] <= ax * bz;
      prod[4] <= ax * by;
      prod[5] <= ay * bx;
    end
  end

  // Cross components.
  logic signed [PW:0] cr [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cr[i] <= {prod[2*i][PW-1], prod[2*i]} - {prod[2*i+1][PW-1], prod[2*i+1]};
      end
    end
  end

  // Magnitudes and signs.
  logic [PW-1:0] mag [3];
  logic [2:0]    neg4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]  <= cr[i][PW] ? PW'(-cr[i]) : cr[i][PW-1:0];
        neg4[i] <= cr[i][PW];
      end
    end
  end

  // Bit length of the largest magnitude.
  logic [PW-1:0]  mag_or;
  logic [BLW-1:0] bl_next;
  assign mag_or = mag[0] | mag[1] | mag[2];
  always_comb begin
    bl_next = '0;
    for (int i = 0; i < PW; i++) begin
      if (mag_or[i]) begin
        bl_next = BLW'(i + 1);
      end
    end
  end

  logic [BLW-1:0] bl;
  logic [PW-1:0]  mag5 [3];
  logic [2:0]     neg5;
  always_ff @(posedge clk) begin
    if (adv) begin
      bl   <= bl_next;
      mag5 <= mag;
      neg5 <= neg4;
    end
  end

  // Scale by 2^(30 - bl): shift the magnitude padded with 30 zeros right by bl.
  logic [PW+NB-1:0] padded [3];
  logic [NB-1:0]    u6 [3];
  logic [2:0]       neg6;
  logic             degen6;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      padded[i] = {mag5[i], {NB{1'b0}}} >> bl;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u6[i] <= padded[i][NB-1:0];
      end
      neg6   <= neg5;
      degen6 <= (bl == '0);
    end
  end

  // Squares of the scaled magnitudes.
  logic [tfn_pkg::SQ_W-1:0] sq7 [3];
  logic [NB-1:0]            u7 [3];
  logic [2:0]               neg7;
  logic                     degen7;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= u6[i] * u6[i];
      end
      u7     <= u6;
      neg7   <= neg6;
      degen7 <= degen6;
    end
  end

  // Sum of squares enters the square root chain.
  tfn_pkg::sqrt_word_t sq_w [SQC+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_w[0] <= '0;
    end else if (adv) begin
      sq_w[0].vld   <= vld[6];
      sq_w[0].rem   <= tfn_pkg::SUM_W'(sq7[0]) + tfn_pkg::SUM_W'(sq7[1])
                       + tfn_pkg::SUM_W'(sq7[2]);
      sq_w[0].root  <= '0;
      for (int i = 0; i < 3; i++) begin
        sq_w[0].u[i] <= u7[i];
      end
      sq_w[0].neg   <= neg7;
      sq_w[0].degen <= degen7;
    end
  end

  for (genvar g = 0; g < SQC; g++) begin : g_sqrt
    tfn_sqrt_cell #(.BIT(SQC - 1 - g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (sq_w[g]),
      .dout (sq_w[g+1])
    );
  end

  // Dividend 2^15*u + L and divisor 2L for round to nearest.
  tfn_pkg::div_word_t dv_w [DVC+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_w[0] <= '0;
    end else if (adv) begin
      dv_w[0].vld <= sq_w[SQC].vld;
      for (int i = 0; i < 3; i++) begin
        dv_w[0].rem[i] <= {1'b0, sq_w[SQC].u[i], {tfn_pkg::QUO_W{1'b0}}}
                          + tfn_pkg::NUM_W'(sq_w[SQC].root);
      end
      dv_w[0].dvs   <= {sq_w[SQC].root, 1'b0};
      dv_w[0].quo   <= '0;
      dv_w[0].neg   <= sq_w[SQC].neg;
      dv_w[0].degen <= sq_w[SQC].degen;
    end
  end

  for (genvar g = 0; g < DVC; g++) begin : g_div
    tfn_div_cell #(.BIT(DVC - 1 - g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (dv_w[g]),
      .dout (dv_w[g+1])
    );
  end

  // Apply signs; a degenerate triangle gives the zero vector.
  logic [tfn_pkg::OUT_W-1:0] nrm_next [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_w[DVC].degen) begin
        nrm_next[i] = '0;
      end else if (dv_w[DVC].neg[i]) begin
        nrm_next[i] = -{1'b0, dv_w[DVC].quo[i]};
      end else begin
        nrm_next[i] = {1'b0, dv_w[DVC].quo[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_w[DVC].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_x   <= nrm_next[0];
      normal_y   <= nrm_next[1];
      normal_z   <= nrm_next[2];
      degenerate <= dv_w[DVC].degen;
    end
  end

  // A degenerate word carries the zero vector.
  `TFN_ASSERT(a_degen_zero, out_valid && degenerate |-> {normal_x, normal_y, normal_z} == '0)
  // A proper triangle yields a nonzero normal.
  `TFN_ASSERT(a_nonzero, out_valid && !degenerate |-> {normal_x, normal_y, normal_z} != '0)
  // normal_x stays within plus or minus one in Q1.14.
  `TFN_ASSERT(a_range, out_valid |-> $signed(normal_x) <= 16384 && $signed(normal_x) >= -16384)
  // Reset empties the output stage.
  `TFN_ASSERT_RST(a_reset, rst |=> !out_valid)

endmodule
`default_nettype wire

>>> rtl/core/tfn_sqrt_cell.sv
`default_nettype none
module tfn_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  wire tfn_pkg::sqrt_word_t din,
  output tfn_pkg::sqrt_word_t      dout
);

  localparam int TW = tfn_pkg::SUM_W + 2;

  logic [TW-1:0]       trial;
  tfn_pkg::sqrt_word_t dout_next;

  // Try setting this root bit: (r + 2^BIT)^2 - r^2 must fit in the remainder.
  always_comb begin
    trial     = (TW'(din.root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    dout_next = din;
    if (TW'(din.rem) >= trial) begin
      dout_next.rem  = din.rem - trial[tfn_pkg::SUM_W-1:0];
      dout_next.root = din.root | (tfn_pkg::ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tfn_div_cell.sv
`default_nettype none
module tfn_div_cell #(
  parameter int BIT = 0
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire tfn_pkg::div_word_t din,
  output tfn_pkg::div_word_t      dout
);

  localparam int TW = tfn_pkg::NUM_W + 1;

  logic [TW-1:0]      trial;
  tfn_pkg::div_word_t dout_next;

  // One restoring quotient bit for each of the three lanes.
  always_comb begin
    trial     = TW'(din.dvs) << BIT;
    dout_next = din;
    for (int l = 0; l < 3; l++) begin
      if ({1'b0, din.rem[l]} >= trial) begin
        dout_next.rem[l] = din.rem[l] - trial[tfn_pkg::NUM_W-1:0];
        dout_next.quo[l] = din.quo[l] | (tfn_pkg::QUO_W'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_triangle_face_normal_top.sv
`default_nettype none
module tb_triangle_face_normal_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 56;
  localparam int N_RANDOM  = 400;
  localparam int CYCLE_CAP = 200000;
  localparam int FW        = tfn_pkg::FIELD_W;
  localparam int OW        = tfn_pkg::OUT_W;

  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          degen;
  } normal_word_t;

  // Keeps the normals predicted for accepted triangles and checks results in order.
  class normal_scoreboard;
    normal_word_t pending[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // Predicts the unit normal of one triangle.
    function normal_word_t face_normal(logic [FW-1:0] v[9]);
      logic signed [32:0]  ax, ay, az, bx, by, bz;
      logic signed [66:0]  c[3];
      logic        [66:0]  mag[3];
      logic        [63:0]  u[3];
      logic        [63:0]  acc, rem, root, bitv, q;
      logic        [66:0]  mx;
      int                  bl, k, i;
      normal_word_t        r;
      ax = $signed(v[6]) - $signed(v[3]);
      ay = $signed(v[7]) - $signed(v[4]);
      az = $signed(v[8]) - $signed(v[5]);
      bx = $signed(v[0]) - $signed(v[3]);
      by = $signed(v[1]) - $signed(v[4]);
      bz = $signed(v[2]) - $signed(v[5]);
      c[0] = ay * bz - az * by;
      c[1] = az * bx - ax * bz;
      c[2] = ax * by - ay * bx;
      mx = 0;
      for (i = 0; i < 3; i++) begin
        mag[i] = c[i][66] ? -c[i] : c[i];
        if (mag[i] > mx) mx = mag[i];
      end
      r = '0;
      if (mx == 0) begin
        r.degen = 1'b1;
        return r;
      end
      bl = 0;
      for (i = 0; i < 67; i++) if (mx[i]) bl = i + 1;
      k = bl - tfn_pkg::NORM_BITS;
      acc = 0;
      for (i = 0; i < 3; i++) begin
        u[i] = (k >= 0) ? 64'(mag[i] >> k) : 64'(mag[i] << (-k));
        acc += u[i] * u[i];
      end
      // Bitwise integer square root.
      rem = acc; root = 0; bitv = 64'd1 << 62;
      while (bitv > acc) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      for (i = 0; i < 3; i++) begin
        q = ((u[i] << (tfn_pkg::UNIT_SHIFT + 1)) + root) / (root << 1);
        if (c[i][66]) q = -q;
        if (i == 0) r.nx = q[OW-1:0];
        else if (i == 1) r.ny = q[OW-1:0];
        else r.nz = q[OW-1:0];
      end
      return r;
    endfunction

    function void note_triangle(logic [FW-1:0] v[9]);
      pending.push_back(face_normal(v));
    endfunction

    function void check_normal(normal_word_t got);
      normal_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected normal word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.nx !== want.nx) begin
        $error("normal_x expected %h actual %h", want.nx, got.nx); errors++;
      end
      if (got.ny !== want.ny) begin
        $error("normal_y expected %h actual %h", want.ny, got.ny); errors++;
      end
      if (got.nz !== want.nz) begin
        $error("normal_z expected %h actual %h", want.nz, got.nz); errors++;
      end
      if (got.degen !== want.degen) begin
        $error("degenerate expected %b actual %b", want.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [FW-1:0] coord[9];
  wire  in_ready, out_valid, degenerate;
  wire  [OW-1:0] normal_x, normal_y, normal_z;

  normal_scoreboard sb = new();
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  int  cycles = 0;

  initial for (int i = 0; i < 9; i++) coord[i] = '0;

  always #1 clk = ~clk;

  triangle_face_normal_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(coord[0]), .first_y(coord[1]), .first_z(coord[2]),
    .middle_x(coord[3]), .middle_y(coord[4]), .middle_z(coord[5]),
    .third_x(coord[6]), .third_y(coord[7]), .third_z(coord[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_triangle_face_normal_top: FAIL");
      $finish;
    end
  end

  // Result side: check accepted words, stall in bursts or for a long hold-off.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_normal({normal_x, normal_y, normal_z, degenerate});
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Random coordinate: full range, multiples of 2^16, small values, or extremes.
  function automatic logic [FW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(0, 8191)) - 4096) << 16;
      2: return 32'($signed($urandom_range(0, 255)) - 128);
      default: return $urandom();
    endcase
  endfunction

  // Offers one triangle and waits until it is accepted.
  task automatic send_triangle(logic [FW-1:0] v[9]);
    for (int i = 0; i < 9; i++) coord[i] <= v[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  logic [FW-1:0] tri_v[9];
  int idle;
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed triangles: unit triangle, all-zero, collinear, extremes, small, all-equal; then eight random ones.
    tri_v = '{32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0};
    send_triangle(tri_v);
    tri_v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(tri_v);
    tri_v = '{32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h20000, 32'h20000, 32'h20000};
    send_triangle(tri_v);
    tri_v = '{32'h7fffffff, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
              0, 32'h7fffffff, 0};
    send_triangle(tri_v);
    tri_v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff};
    send_triangle(tri_v);
    tri_v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
    send_triangle(tri_v);
    tri_v = '{0, 0, 32'hffffffff, 0, 0, 0, 32'hffffffff, 0, 0};
    send_triangle(tri_v);
    tri_v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    send_triangle(tri_v);
    for (int n = 0; n < 8; n++) begin
      for (int i = 0; i < 9; i++) tri_v[i] = rand_coord();
      send_triangle(tri_v);
    end
    // Long receiver hold-off while triangles keep coming.
    fork
      begin
        hold_off = 1'b1;
        idle = 0;
        while (idle < 3 * LATENCY) begin
          @(posedge clk);
          idle++;
        end
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < 100; n++) begin
          for (int i = 0; i < 9; i++) tri_v[i] = rand_coord();
          send_triangle(tri_v);
        end
      end
    join
    // Random triangles; the tail runs without idling.
    for (int n = 0; n < N_RANDOM - 100; n++) begin
      if (n == N_RANDOM - 160) quiet = 1'b1;
      for (int i = 0; i < 9; i++) tri_v[i] = rand_coord();
      if ($urandom_range(0, 19) == 0) tri_v[0] = tri_v[3];
      send_triangle(tri_v);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_triangle_face_normal_top: PASS");
    else
      $display("tb_triangle_face_normal_top: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
